FILE: hdl/bstm_pkg.sv
// ============================================================================
// bstm_pkg - binary search tree map shared definitions
// Command and status codes, sequencer states and node memory write controls.
// ============================================================================
package bstm_pkg;

    // Command codes carried on the request channel
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EXISTS    = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    // Walk sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_COMPARE,
        S_LEAF,
        S_LINK,
        S_RESP
    } t_state;

    // Node memory write strobes
    typedef struct packed {
        logic node;   // key and value at the write address
        logic left;   // left child link
        logic right;  // right child link
    } t_node_wr;

    // Status of a walk that ended without a hit
    function automatic t_status miss_status(input logic [1:0] cmd, input logic full);
        t_status s;
        s = STS_OK;
        case (cmd)
            CMD_INSERT: s = full ? STS_FULL : STS_OK;
            CMD_FIND:   s = STS_NOT_FOUND;
            default:    s = STS_OK;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/bstm_node_ram.sv
// ============================================================================
// bstm_node_ram - node pool storage
// Key, value and child link arrays with one write port and one registered
// read port shared by all arrays.
// ============================================================================
module bstm_node_ram
    import bstm_pkg::*;
#(
    parameter int DEPTH   = 256,
    parameter int VALUE_W = 16
) (
    input  logic                      i_clk,
    input  t_node_wr                  i_wr,
    input  logic [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  logic signed [31:0]        i_wr_key,
    input  logic [VALUE_W-1:0]        i_wr_value,
    input  logic [$clog2(DEPTH):0]    i_wr_link,
    input  logic [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic signed [31:0]        o_rd_key,
    output logic [VALUE_W-1:0]        o_rd_value,
    output logic [$clog2(DEPTH):0]    o_rd_left,
    output logic [$clog2(DEPTH):0]    o_rd_right
);

    localparam int LW = $clog2(DEPTH) + 1;

    logic signed [31:0]  r_key_mem   [DEPTH];
    logic [VALUE_W-1:0]  r_value_mem [DEPTH];
    logic [LW-1:0]       r_left_mem  [DEPTH];
    logic [LW-1:0]       r_right_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.node) begin
            r_key_mem[i_wr_addr]   <= i_wr_key;
            r_value_mem[i_wr_addr] <= i_wr_value;
        end
        if (i_wr.left) begin
            r_left_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_wr.right) begin
            r_right_mem[i_wr_addr] <= i_wr_link;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_value <= r_value_mem[i_rd_addr];
        o_rd_left  <= r_left_mem[i_rd_addr];
        o_rd_right <= r_right_mem[i_rd_addr];
    end

endmodule

FILE: hdl/binary_search_tree_map.sv
// ============================================================================
// binary_search_tree_map - keyed map on an unbalanced binary search tree
// Insert, find and clear over a fixed node pool, walked one node at a time
// by a small sequencer around a single signed key comparator.
// ============================================================================
//
//  Channel    Direction  Handshake                     Payload
//  command    in         i_cmd_valid / o_cmd_ready     i_cmd, i_key, i_value
//  response   out        o_rsp_valid / i_rsp_ready     o_result_status, o_found_value
//
// Insert and find visit each tree level with a memory read, then a compare;
// an insert that misses writes the new leaf, then links it under its parent
// if it has one. Clear goes straight to the response. The tree depth, up to
// the number of stored nodes, sets the walk length.
// Reset (synchronous, active low) empties the tree; no memory sweep is needed.
// One request is in work at a time; a pending response does not block the
// next request, but a finished walk waits in S_RESP until the response is free.
//
module binary_search_tree_map
    import bstm_pkg::*;
#(
    parameter int MAX_NODES   = 256,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_ready,
    input  logic [1:0]              i_cmd,
    input  logic signed [31:0]      i_key,
    input  logic [VALUE_WIDTH-1:0]  i_value,
    output logic                    o_rsp_valid,
    input  logic                    i_rsp_ready,
    output logic [1:0]              o_result_status,
    output logic [VALUE_WIDTH-1:0]  o_found_value
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] NIL = LW'(MAX_NODES);

    t_state                    r_state, n_state;
    logic [1:0]                r_cmd;
    logic signed [31:0]        r_key;
    logic [VALUE_WIDTH-1:0]    r_value;
    logic [AW-1:0]             r_cur;
    logic [AW-1:0]             r_last;
    logic                      r_go_left;
    logic                      r_has_last;
    logic [AW-1:0]             r_root;
    logic                      r_root_valid;
    logic [LW-1:0]             r_used;
    t_status                   r_status;
    logic [VALUE_WIDTH-1:0]    r_found;
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic [VALUE_WIDTH-1:0]    r_out_found;

    logic                      accept;
    logic                      full;
    logic                      key_eq;
    logic                      key_lt;
    logic [LW-1:0]             next_link;
    logic                      next_nil;
    logic                      out_load;
    t_node_wr                  ram_wr;
    logic [AW-1:0]             ram_wr_addr;
    logic [LW-1:0]             ram_wr_link;
    logic signed [31:0]        rd_key;
    logic [VALUE_WIDTH-1:0]    rd_value;
    logic [LW-1:0]             rd_left;
    logic [LW-1:0]             rd_right;

    // Node pool
    bstm_node_ram #(
        .DEPTH   (MAX_NODES),
        .VALUE_W (VALUE_WIDTH)
    ) u_node_ram (
        .i_clk      (i_clk),
        .i_wr       (ram_wr),
        .i_wr_addr  (ram_wr_addr),
        .i_wr_key   (r_key),
        .i_wr_value (r_value),
        .i_wr_link  (ram_wr_link),
        .i_rd_addr  (r_cur),
        .o_rd_key   (rd_key),
        .o_rd_value (rd_value),
        .o_rd_left  (rd_left),
        .o_rd_right (rd_right)
    );

    // Shared comparator and child selection
    assign key_eq    = (r_key == rd_key);
    assign key_lt    = (r_key < rd_key);
    assign next_link = key_lt ? rd_left : rd_right;
    assign next_nil  = (next_link >= NIL);
    assign full      = (r_used >= NIL);
    assign accept    = i_cmd_valid && o_cmd_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_INSERT: begin
                            if (r_root_valid)  n_state = S_FETCH;
                            else if (full)     n_state = S_RESP;
                            else               n_state = S_LEAF;
                        end
                        CMD_FIND: n_state = r_root_valid ? S_FETCH : S_RESP;
                        default:  n_state = S_RESP;
                    endcase
                end
            end
            S_FETCH:   n_state = S_COMPARE;
            S_COMPARE: begin
                if (key_eq)                                  n_state = S_RESP;
                else if (!next_nil)                          n_state = S_FETCH;
                else if (r_cmd == CMD_INSERT && !full)       n_state = S_LEAF;
                else                                         n_state = S_RESP;
            end
            S_LEAF:    n_state = r_has_last ? S_LINK : S_RESP;
            S_LINK:    n_state = S_RESP;
            S_RESP:    n_state = out_load ? S_IDLE : S_RESP;
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_cmd_ready = 1'b0;
        out_load    = 1'b0;
        ram_wr      = '0;
        ram_wr_addr = r_used[AW-1:0];
        ram_wr_link = NIL;
        unique case (r_state)
            S_IDLE: o_cmd_ready = 1'b1;
            S_LEAF: begin
                ram_wr.node  = 1'b1;
                ram_wr.left  = 1'b1;
                ram_wr.right = 1'b1;
            end
            S_LINK: begin
                ram_wr_addr  = r_last;
                ram_wr_link  = r_used;
                ram_wr.left  = r_go_left;
                ram_wr.right = !r_go_left;
            end
            S_RESP:  out_load = !r_out_valid || i_rsp_ready;
            default: ;
        endcase
    end

    // Walk and tree control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_root_valid <= 1'b0;
            r_root       <= '0;
            r_used       <= '0;
            r_has_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_has_last <= 1'b0;
                        if (i_cmd == CMD_CLEAR) begin
                            r_root_valid <= 1'b0;
                            r_used       <= '0;
                        end
                    end
                end
                S_COMPARE: begin
                    if (!key_eq && next_nil) begin
                        r_has_last <= 1'b1;
                    end
                end
                S_LEAF: begin
                    if (!r_has_last) begin
                        r_root       <= r_used[AW-1:0];
                        r_root_valid <= 1'b1;
                        r_used       <= r_used + LW'(1);
                    end
                end
                S_LINK:  r_used <= r_used + LW'(1);
                default: ;
            endcase
        end
    end

    // Request payload and walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cmd   <= i_cmd;
                    r_key   <= i_key;
                    r_value <= i_value;
                    r_cur   <= r_root;
                    r_found <= '0;
                    if ((i_cmd == CMD_INSERT || i_cmd == CMD_FIND) && !r_root_valid) begin
                        r_status <= miss_status(i_cmd, full);
                    end else begin
                        r_status <= STS_OK;
                    end
                end
            end
            S_COMPARE: begin
                if (key_eq) begin
                    if (r_cmd == CMD_INSERT) begin
                        r_status <= STS_EXISTS;
                    end else begin
                        r_status <= STS_OK;
                        r_found  <= rd_value;
                    end
                end else if (next_nil) begin
                    r_last    <= r_cur;
                    r_go_left <= key_lt;
                    r_status  <= miss_status(r_cmd, full);
                end else begin
                    r_cur <= next_link[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
            r_out_found  <= r_found;
        end
    end

    assign o_rsp_valid     = r_out_valid;
    assign o_result_status = r_out_status;
    assign o_found_value   = r_out_found;

    // Pool count never passes the pool size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NIL)
        else $error("node count beyond pool size");

    // An empty tree holds no allocated nodes
    a_empty_tree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_root_valid |-> r_used == '0)
        else $error("nodes allocated with no root");

    // A clear request empties the tree at once
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_CLEAR) |=> (!r_root_valid && r_used == '0))
        else $error("clear left nodes in the tree");

    // Every compare follows a memory read
    a_compare_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_COMPARE |-> $past(r_state) == S_FETCH)
        else $error("compare without memory read");

endmodule
